// File: design/mdio_mm_pkg.sv
// ----------------------------------------------------------------------------
// MDIO management master package
// Shared widths, frame constants and operation codes for the clause 22
// management master and its channel interfaces.
// ----------------------------------------------------------------------------
package mdio_mm_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned OpW       = 2;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 16;
  localparam int unsigned HalfW     = 16;

  // Frame layout: preamble ones, then start, opcode, addresses,
  // turnaround and data held in one 32-bit shift word.
  localparam int unsigned PreambleBits = 32;
  localparam int unsigned TailBits     = 32;
  localparam int unsigned TotalBits    = PreambleBits + TailBits;
  localparam int unsigned BitPosW      = $clog2(TotalBits + 1);
  localparam int unsigned TaPos        = PreambleBits + 14;
  localparam int unsigned DataPos      = PreambleBits + 16;

  // Reset value of the half-period register.
  localparam logic [HalfW-1:0] HalfPeriodReset = HalfW'(1000);

  // Operation codes of the request channel.
  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_READ  = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE = 2'd2;

  // Opcode fields placed in the frame.
  localparam logic [1:0] FRAME_START    = 2'b01;
  localparam logic [1:0] FRAME_OP_READ  = 2'b10;
  localparam logic [1:0] FRAME_OP_WRITE = 2'b01;
  localparam logic [1:0] FRAME_TA_WRITE = 2'b10;

endpackage

// File: design/mdio_mm_ifs.sv
// ----------------------------------------------------------------------------
// MDIO management master channel interfaces
// Valid/ready channels carrying one time-base tick in and one status out.
// ----------------------------------------------------------------------------

// Request channel: one tick, optionally starting a transaction.
interface mdio_mm_req_if import mdio_mm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [AddrW-1:0] phy_addr;
  logic [AddrW-1:0] reg_addr;
  logic [DataW-1:0] write_data;
  logic             mdio_in;

  modport source (output valid, op, phy_addr, reg_addr, write_data, mdio_in,
                  input ready);
  modport sink   (input valid, op, phy_addr, reg_addr, write_data, mdio_in,
                  output ready);
endinterface

// Response channel: bus levels and status after one tick.
interface mdio_mm_rsp_if import mdio_mm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mdc_level;
  logic             mdio_out;
  logic             mdio_drive;
  logic             busy_res;
  logic [DataW-1:0] read_data;
  logic             done_res;
  logic             rejected;

  modport source (output valid, mdc_level, mdio_out, mdio_drive, busy_res,
                  read_data, done_res, rejected, input ready);
  modport sink   (input valid, mdc_level, mdio_out, mdio_drive, busy_res,
                  read_data, done_res, rejected, output ready);
endinterface

// File: design/mdio_management_master_unit.sv
// ----------------------------------------------------------------------------
// MDIO management master unit
// Clause 22 management-bus master driven by a stream of time-base ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on in_if is one tick of the time base. A tick with op
//   read or write starts a frame when the unit is idle; a start request while
//   a frame is running is ignored and flagged by rejected. Every accepted tick
//   produces exactly one transaction on out_if carrying the MDC level, the
//   data line drive enable and level, busy, done and the last read word.
//   cfg_we/cfg_wdata write the half period of MDC in ticks (0 acts as 1);
//   write it only while no frame is running.
//   The response to an accepted tick is registered and appears in the next
//   cycle. Throughput is one tick per cycle: the divider, bit counter and frame
//   shift word advance in one pass of logic ahead of the output register.
//   When out_if stalls, the output register holds the pending response and
//   in_if.ready drops, so no tick is lost or processed twice.
//   Reset clears the frame state and read word, releases the data line and
//   loads the half period with 1000 ticks.
// ----------------------------------------------------------------------------
module mdio_management_master_unit import mdio_mm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mdio_mm_req_if.sink      in_if,
  mdio_mm_rsp_if.source    out_if,
  input  logic             cfg_we,
  input  logic [HalfW-1:0] cfg_wdata
);

  // Configuration and frame state.
  logic [HalfW-1:0]   half_period_r;
  logic [BitPosW-1:0] bit_pos_r,     bit_pos_nxt;
  logic               clock_high_r,  clock_high_nxt;
  logic [HalfW-1:0]   div_cnt_r,     div_cnt_nxt;
  logic [31:0]        frame_r,       frame_nxt;
  logic [DataW-1:0]   read_shift_r,  read_shift_nxt;
  logic               active_r,      active_nxt;
  logic               is_read_r,     is_read_nxt;
  logic               driving_r,     driving_nxt;
  logic [DataW-1:0]   last_read_r,   last_read_nxt;

  // Output register.
  logic               out_valid_r;
  logic               mdc_r,        mdc_nxt;
  logic               mdio_out_r,   mdio_out_nxt;
  logic               mdio_drive_r, mdio_drive_nxt;
  logic               done_r,       done_nxt;
  logic               rejected_r,   rejected_nxt;

  logic               in_fire;
  logic               request;
  logic               start_read;
  logic [HalfW:0]     div_inc;
  logic               div_wrap;
  logic [BitPosW-1:0] bit_pos_inc;
  logic [BitPosW-1:0] tail_idx;
  logic               line_level;

  // The next tick is taken whenever the output register is free or drains.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign request     = (in_if.op == OP_READ) || (in_if.op == OP_WRITE);
  assign start_read  = (in_if.op == OP_READ);
  assign div_inc     = {1'b0, div_cnt_r} + (HalfW+1)'(1);
  assign div_wrap    = div_inc >= {1'b0, half_period_r};
  assign bit_pos_inc = bit_pos_r + BitPosW'(1);

  // Frame sequencing for one tick.
  always_comb begin
    bit_pos_nxt    = bit_pos_r;
    clock_high_nxt = clock_high_r;
    div_cnt_nxt    = div_cnt_r;
    frame_nxt      = frame_r;
    read_shift_nxt = read_shift_r;
    active_nxt     = active_r;
    is_read_nxt    = is_read_r;
    driving_nxt    = driving_r;
    last_read_nxt  = last_read_r;
    done_nxt       = 1'b0;
    rejected_nxt   = 1'b0;
    if (active_r) begin
      rejected_nxt = request;
      if (div_wrap) begin
        div_cnt_nxt = '0;
        if (!clock_high_r) begin
          // Rising edge of MDC: sample a read data bit seen while MDC was low.
          if (is_read_r && (bit_pos_r >= BitPosW'(DataPos))) begin
            read_shift_nxt = {read_shift_r[DataW-2:0], in_if.mdio_in};
          end
          clock_high_nxt = 1'b1;
        end else begin
          // Falling edge of MDC: move to the next bit or end the frame.
          clock_high_nxt = 1'b0;
          if ({1'b0, bit_pos_inc} >= (BitPosW+1)'(TotalBits)) begin
            active_nxt  = 1'b0;
            driving_nxt = 1'b0;
            bit_pos_nxt = '0;
            done_nxt    = 1'b1;
            if (is_read_r) begin
              last_read_nxt = read_shift_r;
            end
          end else begin
            bit_pos_nxt = bit_pos_inc;
            driving_nxt = !(is_read_r && (bit_pos_inc >= BitPosW'(TaPos)));
          end
        end
      end else begin
        div_cnt_nxt = div_inc[HalfW-1:0];
      end
    end else if (request) begin
      // Start of a frame: load the shift word and begin bit 0 low.
      is_read_nxt    = start_read;
      frame_nxt      = {FRAME_START,
                        start_read ? FRAME_OP_READ : FRAME_OP_WRITE,
                        in_if.phy_addr, in_if.reg_addr,
                        start_read ? 2'b00 : FRAME_TA_WRITE,
                        start_read ? '0 : in_if.write_data};
      read_shift_nxt = '0;
      bit_pos_nxt    = '0;
      clock_high_nxt = 1'b0;
      div_cnt_nxt    = '0;
      active_nxt     = 1'b1;
      driving_nxt    = 1'b1;
    end
  end

  // Data line level for the bit now on the bus.
  always_comb begin
    tail_idx   = bit_pos_nxt - BitPosW'(PreambleBits);
    line_level = 1'b0;
    if (bit_pos_nxt < BitPosW'(PreambleBits)) begin
      line_level = 1'b1;
    end else if (tail_idx < BitPosW'(TailBits)) begin
      line_level = frame_nxt[5'd31 - tail_idx[4:0]];
    end
  end

  // Response fields as seen after this tick.
  always_comb begin
    mdc_nxt        = active_nxt && clock_high_nxt;
    mdio_drive_nxt = active_nxt && driving_nxt;
    mdio_out_nxt   = active_nxt && driving_nxt && line_level;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HalfPeriodReset;
    end else if (cfg_we) begin
      half_period_r <= cfg_wdata;
    end
  end

  // State and output registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r    <= '0;
      clock_high_r <= 1'b0;
      div_cnt_r    <= '0;
      frame_r      <= '0;
      read_shift_r <= '0;
      active_r     <= 1'b0;
      is_read_r    <= 1'b0;
      driving_r    <= 1'b0;
      last_read_r  <= '0;
      out_valid_r  <= 1'b0;
      mdc_r        <= 1'b0;
      mdio_out_r   <= 1'b0;
      mdio_drive_r <= 1'b0;
      done_r       <= 1'b0;
      rejected_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        bit_pos_r    <= bit_pos_nxt;
        clock_high_r <= clock_high_nxt;
        div_cnt_r    <= div_cnt_nxt;
        frame_r      <= frame_nxt;
        read_shift_r <= read_shift_nxt;
        active_r     <= active_nxt;
        is_read_r    <= is_read_nxt;
        driving_r    <= driving_nxt;
        last_read_r  <= last_read_nxt;
        mdc_r        <= mdc_nxt;
        mdio_out_r   <= mdio_out_nxt;
        mdio_drive_r <= mdio_drive_nxt;
        done_r       <= done_nxt;
        rejected_r   <= rejected_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.mdc_level  = mdc_r;
  assign out_if.mdio_out   = mdio_out_r;
  assign out_if.mdio_drive = mdio_drive_r;
  assign out_if.busy_res   = active_r;
  assign out_if.read_data  = last_read_r;
  assign out_if.done_res   = done_r;
  assign out_if.rejected   = rejected_r;

  // A finished frame is never reported as still busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !active_r)
    else $error("done reported while frame still active");

  // The data line is never driven high while released.
  assert property (@(posedge clk) disable iff (!rst_n)
    mdio_out_r |-> mdio_drive_r)
    else $error("data level set while line released");

  // A start request during a frame, on a tick where the divider does not wrap, is flagged and leaves the frame running.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && request && active_r && !div_wrap |=> rejected_r && active_r)
    else $error("busy start request not rejected");

  // The MDC level only changes when the divider wraps.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && active_r && !div_wrap |=> $stable(clock_high_r))
    else $error("MDC toggled without divider wrap");

endmodule

// File: bench/tb_mdio_management_master_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the MDIO management master unit
// Streams time-base ticks into the unit at the reset half period, then runs
// read and write frames at several MDC half periods, from zero up to the
// largest value. A scoreboard predicts every status transaction and compares
// it, field by field, with what the unit returns. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module tb_mdio_management_master_unit;
  import mdio_mm_pkg::*;

  // Opcode three has no meaning and is treated as a plain tick.
  localparam logic [OpW-1:0] OP_UNUSED  = 2'd3;
  localparam int unsigned    CycleLimit = 200000;
  localparam int unsigned    RandomTicks = 960;

  // One tick on the request channel.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] phy_addr;
    logic [AddrW-1:0] reg_addr;
    logic [DataW-1:0] write_data;
    logic             mdio_in;
  } tick_t;

  // One status transaction on the response channel.
  typedef struct packed {
    logic             mdc_level;
    logic             mdio_out;
    logic             mdio_drive;
    logic             busy_res;
    logic [DataW-1:0] read_data;
    logic             done_res;
    logic             rejected;
  } status_t;

  // Tracks the bus state the unit should be in and queues the status
  // transactions it should produce.
  class mdio_status_board;
    logic [HalfW-1:0] half_ticks;
    logic [6:0]       bit_pos;
    logic             mdc_high;
    logic [HalfW-1:0] div_count;
    logic [31:0]      frame_word;
    logic [DataW-1:0] rd_shift;
    logic             running;
    logic             read_frame;
    logic             drive_en;
    logic [DataW-1:0] read_word;
    status_t          predicted_q[$];
    int unsigned      error_count;

    function new();
      half_ticks  = HalfPeriodReset;
      bit_pos     = '0;
      mdc_high    = 1'b0;
      div_count   = '0;
      frame_word  = '0;
      rd_shift    = '0;
      running     = 1'b0;
      read_frame  = 1'b0;
      drive_en    = 1'b0;
      read_word   = '0;
      error_count = 0;
    endfunction

    function void set_half_period(logic [HalfW-1:0] value);
      half_ticks = value;
    endfunction

    function bit busy();
      return running;
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    // A half period of zero ends after one tick, like a half period of one.
    function bit half_ends();
      return ({1'b0, div_count} + 17'd1) >= {1'b0, half_ticks};
    endfunction

    // True when the next tick closes the last high half of the frame.
    function bit finishing_next();
      return running && mdc_high && half_ends() && (bit_pos + 7'd1 >= 7'(TotalBits));
    endfunction

    // Level of the current bit: preamble ones, then the frame word MSB first.
    function logic frame_bit();
      int unsigned k;
      if (bit_pos < PreambleBits) return 1'b1;
      k = int'(bit_pos) - PreambleBits;
      return frame_word[31 - k];
    endfunction

    // Advances the bus state by one accepted tick and queues its status.
    function void note_tick(tick_t t);
      status_t s;
      logic    request;
      logic    done;
      logic    rej;
      request = (t.op == OP_READ) || (t.op == OP_WRITE);
      done    = 1'b0;
      rej     = 1'b0;
      if (running) begin
        rej = request;
        if (half_ends()) begin
          div_count = '0;
          if (!mdc_high) begin
            // Read bits are taken as MDC rises, from the level seen while low.
            if (read_frame && bit_pos >= DataPos) rd_shift = {rd_shift[DataW-2:0], t.mdio_in};
            mdc_high = 1'b1;
          end else begin
            mdc_high = 1'b0;
            bit_pos  = bit_pos + 7'd1;
            if (bit_pos >= TotalBits) begin
              running  = 1'b0;
              drive_en = 1'b0;
              bit_pos  = '0;
              done     = 1'b1;
              if (read_frame) read_word = rd_shift;
            end else begin
              drive_en = !(read_frame && bit_pos >= TaPos);
            end
          end
        end else begin
          div_count = div_count + 1'b1;
        end
      end else if (request) begin
        // The request tick is the first tick of the low half of bit zero.
        read_frame = (t.op == OP_READ);
        frame_word = {FRAME_START, read_frame ? FRAME_OP_READ : FRAME_OP_WRITE,
                      t.phy_addr, t.reg_addr,
                      read_frame ? 2'b00 : FRAME_TA_WRITE,
                      read_frame ? 16'h0000 : t.write_data};
        rd_shift   = '0;
        bit_pos    = '0;
        mdc_high   = 1'b0;
        div_count  = '0;
        running    = 1'b1;
        drive_en   = !(read_frame && bit_pos >= TaPos);
      end
      s.mdc_level  = running & mdc_high;
      s.mdio_drive = running & drive_en;
      s.mdio_out   = (running && drive_en) ? frame_bit() : 1'b0;
      s.busy_res   = running;
      s.read_data  = read_word;
      s.done_res   = done;
      s.rejected   = rej;
      predicted_q.push_back(s);
    endfunction

    function void compare_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        error_count++;
      end
    endfunction

    // Compares one status transaction with the oldest prediction.
    function void check_status(status_t got);
      status_t want;
      if (predicted_q.size() == 0) begin
        $error("status transaction arrived with no tick waiting for it");
        error_count++;
        return;
      end
      want = predicted_q.pop_front();
      compare_field("mdc_level", DataW'(want.mdc_level), DataW'(got.mdc_level));
      compare_field("mdio_out", DataW'(want.mdio_out), DataW'(got.mdio_out));
      compare_field("mdio_drive", DataW'(want.mdio_drive), DataW'(got.mdio_drive));
      compare_field("busy_res", DataW'(want.busy_res), DataW'(got.busy_res));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("done_res", DataW'(want.done_res), DataW'(got.done_res));
      compare_field("rejected", DataW'(want.rejected), DataW'(got.rejected));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [HalfW-1:0] cfg_wdata;
  int unsigned      cycle_count = 0;
  int unsigned      send_count = 0;
  int unsigned      send_calm = 0;
  mdio_status_board board;

  mdio_mm_req_if in_if ();
  mdio_mm_rsp_if out_if ();

  mdio_management_master_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // A tick with every field random and no request.
  function automatic tick_t any_tick();
    tick_t t;
    t.op         = OP_TICK;
    t.phy_addr   = AddrW'($urandom);
    t.reg_addr   = AddrW'($urandom);
    t.write_data = DataW'($urandom);
    t.mdio_in    = 1'($urandom);
    return t;
  endfunction

  // Idle noise: plain ticks and the meaningless opcode.
  function automatic tick_t noise_tick();
    tick_t t;
    t = any_tick();
    if ($urandom_range(0, 2) == 0) t.op = OP_UNUSED;
    return t;
  endfunction

  // Ticks during a frame, now and then carrying a request that must be refused.
  function automatic tick_t busy_tick();
    tick_t t;
    t = any_tick();
    case ($urandom_range(0, 15))
      0: t.op = OP_READ;
      1: t.op = OP_WRITE;
      2: t.op = OP_UNUSED;
      default: t.op = OP_TICK;
    endcase
    return t;
  endfunction

  // Sends one tick after a random gap, waits for its transaction and notes it.
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= t.op;
    in_if.phy_addr   <= t.phy_addr;
    in_if.reg_addr   <= t.reg_addr;
    in_if.write_data <= t.write_data;
    in_if.mdio_in    <= t.mdio_in;
    do @(posedge clk); while (!in_if.ready);
    board.note_tick(t);
    send_count++;
  endtask

  // Starts a frame and keeps ticking until it ends; optionally puts a
  // request on the very tick that finishes the frame.
  task automatic run_frame(input tick_t start, input bit hit_last);
    tick_t t;
    send_tick(start);
    while (board.busy()) begin
      t = busy_tick();
      if (hit_last && board.finishing_next()) t.op = OP_WRITE;
      send_tick(t);
    end
  endtask

  // Holds off the sender until every predicted status has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Writes the half period once the unit is idle.
  task automatic set_half_period(input logic [HalfW-1:0] value);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_half_period(value);
  endtask

  // Status side: random stalls, then checks every accepted transaction.
  initial begin : status_sink
    int unsigned stall;
    int unsigned calm;
    status_t     got;
    calm = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 12);
        if ($urandom_range(0, 40) == 0) calm = $urandom_range(10, 60);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = {out_if.mdc_level, out_if.mdio_out, out_if.mdio_drive, out_if.busy_res,
             out_if.read_data, out_if.done_res, out_if.rejected};
      board.check_status(got);
    end
  end

  // Stimulus: directed ticks and frames first, then random phases, then the largest
  // half period.
  initial begin : stimulus
    tick_t       t;
    logic [HalfW-1:0] hp;
    int unsigned frames;
    board = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.op         <= OP_TICK;
    in_if.phy_addr   <= '0;
    in_if.reg_addr   <= '0;
    in_if.write_data <= '0;
    in_if.mdio_in    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset half period: plain ticks, all-zero and all-one fields.
    t = '0;
    send_tick(t);
    t = '1;
    send_tick(t);
    repeat (4) send_tick(noise_tick());

    // Zero half period: read with top addresses, refused requests while busy
    // and on the finishing tick.
    set_half_period('0);
    t = any_tick();
    t.op       = OP_READ;
    t.phy_addr = '1;
    t.reg_addr = '1;
    run_frame(t, 1'b1);

    // Write with zero addresses and all-one data, then a write started on the
    // tick right after; read_data must keep the read word.
    t = any_tick();
    t.op         = OP_WRITE;
    t.phy_addr   = '0;
    t.reg_addr   = '0;
    t.write_data = '1;
    run_frame(t, 1'b1);
    t.write_data = '0;
    t.phy_addr   = 5'd10;
    t.reg_addr   = 5'd21;
    run_frame(t, 1'b0);

    // Random phases at small half periods.
    while (send_count < RandomTicks) begin
      case ($urandom_range(0, 4))
        0: hp = 16'd0;
        1, 2: hp = 16'd1;
        3: hp = 16'd2;
        default: hp = 16'd3;
      endcase
      set_half_period(hp);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames && send_count < RandomTicks; f++) begin
        repeat ($urandom_range(0, 4)) send_tick(noise_tick());
        t = any_tick();
        t.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        run_frame(t, $urandom_range(0, 3) == 0);
      end
    end

    // Largest half period: the divider runs but MDC never toggles here.
    set_half_period('1);
    t = any_tick();
    t.op = OP_WRITE;
    send_tick(t);
    repeat (60) send_tick(busy_tick());

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
